@@ src/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation, order and status codes,
// the controller-to-datapath command and status structs. No dependencies.
package rau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;
   localparam logic [1:0] ORD_NONE    = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DIVZ   = 2'd1;
   localparam logic [1:0] ST_OVFL   = 2'd2;

   // controller commands to the datapath
   typedef struct packed {
      logic load;     // capture operands
      logic prod;     // form products (multiplier outputs registered)
      logic comb;     // combine products into fraction magnitudes
      logic gcd_init; // start Euclid
      logic rem_step; // one restoring-division bit step
      logic rem_swap; // x <= y, y <= remainder, restart division
      logic qinit;    // start quotient pass (n / g or d / g)
      logic qsel_den; // quotient pass works on the denominator
      logic fin;      // form the result word
   } rau_cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic div_last; // last bit step of the current division
      logic y_zero;   // Euclid divisor is zero
      logic trivial;  // no reduction needed (special forms)
   } rau_sts_type;

endpackage

@@ src/rau_if.sv @@
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
interface rau_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/rational_arithmetic_unit.sv @@
// Rational arithmetic unit top level: wires the controller and datapath to
// the request and response channels. Depends on rau_pkg, rau_ctrl,
// rau_dpath.
//
// Use: present a word on req (operation, a_num, a_den, b_num, b_den); the
// unit returns one word on rsp (res_num, res_den, order, status).
// One word is in flight at a time: req_ready is high only while idle.
// Sequence after acceptance: products, combine and the special-form check,
// then Euclid on the (2*WIDTH+1)-bit magnitudes through one bit-serial
// remainder unit, then two quotient passes, then the result is formed.
// Special forms (zero denominator, zero numerator, compare, unused codes)
// skip Euclid and the quotient passes and go from the special-form check
// straight to forming the result.
// After the result is taken the unit returns to idle, where the next word
// is accepted.
// Reset returns the controller to idle with no word pending.
// A stalled receiver holds rsp_valid and the result word steady and keeps
// req_ready low until the result is taken.
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic [1:0]  rsp_order,
   output logic [1:0]  rsp_status
);

   rau_cmd_type cmd;
   rau_sts_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_dpath #(.WIDTH(WIDTH)) u_dpath (
      .clock         (clock),
      .req_operation (req_operation),
      .req_a_num     (req_a_num),
      .req_a_den     (req_a_den),
      .req_b_num     (req_b_num),
      .req_b_den     (req_b_den),
      .cmd           (cmd),
      .sts           (sts),
      .res_num       (rsp_res_num),
      .res_den       (rsp_res_den),
      .res_order     (rsp_order),
      .res_status    (rsp_status)
   );

endmodule

@@ src/rau_ctrl.sv @@
// Controller state machine for the rational arithmetic unit.
// Depends on rau_pkg for the command and status structs.
module rau_ctrl import rau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  rau_sts_type sts,
   output rau_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PROD  = 4'd1;
   localparam logic [3:0] S_COMB  = 4'd2;
   localparam logic [3:0] S_GINIT = 4'd3;
   localparam logic [3:0] S_GCD   = 4'd4;
   localparam logic [3:0] S_QN    = 4'd5;
   localparam logic [3:0] S_QD    = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_QDI   = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // sequence one word through products, Euclid and the two quotient passes
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = 1'b1;
            if (req_valid) state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_GINIT;
         end
         S_GINIT: begin
            if (sts.trivial) begin
               state_in = S_FIN;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (sts.y_zero) begin
               cmd.qinit = 1'b1;
               state_in  = S_QN;
            end else if (sts.div_last) begin
               cmd.rem_step = 1'b1;
               cmd.rem_swap = 1'b1;
            end else begin
               cmd.rem_step = 1'b1;
            end
         end
         S_QN: begin
            cmd.rem_step = 1'b1;
            if (sts.div_last) state_in = S_QDI;
         end
         S_QDI: begin
            cmd.qinit    = 1'b1;
            cmd.qsel_den = 1'b1;
            state_in     = S_QD;
         end
         S_QD: begin
            cmd.rem_step = 1'b1;
            cmd.qsel_den = 1'b1;
            if (sts.div_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // a result is only shown in the output state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("rsp and req both open");
   // an unaccepted result holds the output state
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   // an accepted word leaves idle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PROD) else $error("word lost");

endmodule

@@ src/rau_dpath.sv @@
// Datapath of the rational arithmetic unit: products, signed combine,
// bit-serial remainder unit shared by Euclid and the quotient passes.
// Depends on rau_pkg.
module rau_dpath import rau_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic              clock,
   input  logic [2:0]        req_operation,
   input  logic [31:0]       req_a_num,
   input  logic [31:0]       req_a_den,
   input  logic [31:0]       req_b_num,
   input  logic [31:0]       req_b_den,
   input  rau_cmd_type       cmd,
   output rau_sts_type       sts,
   output logic [31:0]       res_num,
   output logic [30:0]       res_den,
   output logic [1:0]        res_order,
   output logic [1:0]        res_status
);

   localparam int DW = 2 * WIDTH + 1;   // sum of two double-width products
   localparam int CW = $clog2(DW + 1);

   logic [2:0]         op_ff;
   logic signed [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [2*WIDTH-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic               s1_ff, s2_ff, s3_ff, s4_ff;
   logic               ad0_ff, bd0_ff, bn0_ff;
   logic               nneg_ff, dneg_ff, divz_ff, cmp_gt_ff, cmp_eq_ff;
   logic [DW-1:0]      nmag_ff, dmag_ff;
   logic [DW-1:0]      x_ff, y_ff, q_ff, r_ff, dvd_ff;
   logic [CW-1:0]      cnt_ff;
   logic [DW-1:0]      g_ff, n_ff;
   logic [31:0]        res_num_ff;
   logic [30:0]        res_den_ff;
   logic [1:0]         order_ff, status_ff;

   logic [WIDTH-1:0] ma, md, mbn, mbd;
   assign ma  = an_ff[WIDTH-1] ? -an_ff : an_ff;
   assign md  = ad_ff[WIDTH-1] ? -ad_ff : ad_ff;
   assign mbn = bn_ff[WIDTH-1] ? -bn_ff : bn_ff;
   assign mbd = bd_ff[WIDTH-1] ? -bd_ff : bd_ff;

   // capture operands in idle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         an_ff <= req_a_num[WIDTH-1:0];
         ad_ff <= req_a_den[WIDTH-1:0];
         bn_ff <= req_b_num[WIDTH-1:0];
         bd_ff <= req_b_den[WIDTH-1:0];
      end
   end

   // form the operand products: p1=an*bd p2=ad*bn p3=ad*bd p4=an*bn
   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         p1_ff  <= ma * mbd;
         p2_ff  <= md * mbn;
         p3_ff  <= md * mbd;
         p4_ff  <= ma * mbn;
         s1_ff  <= an_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
         s2_ff  <= ad_ff[WIDTH-1] ^ bn_ff[WIDTH-1];
         s3_ff  <= ad_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
         s4_ff  <= an_ff[WIDTH-1] ^ bn_ff[WIDTH-1];
         ad0_ff <= (ad_ff == '0);
         bd0_ff <= (bd_ff == '0);
         bn0_ff <= (bn_ff == '0);
      end
   end

   // combine products into the fraction to reduce
   logic          qneg_c, sneg_c, ge_c;
   logic [DW-1:0] ep1, ep2, sm_c;
   assign ep1    = {1'b0, p1_ff};
   assign ep2    = {1'b0, p2_ff};
   assign qneg_c = s2_ff ^ (op_ff == OP_SUB);
   assign ge_c   = (p1_ff >= p2_ff);
   always_comb begin
      if (s1_ff == qneg_c) begin
         sneg_c = s1_ff;
         sm_c   = ep1 + ep2;
      end else if (ge_c) begin
         sneg_c = s1_ff;
         sm_c   = ep1 - ep2;
      end else begin
         sneg_c = qneg_c;
         sm_c   = ep2 - ep1;
      end
   end

   // compare: with both denominators made positive, x = an*bd takes the sign
   // of an times the sign of ad, and y = ad*bn the sign of bn times that of bd
   logic sx, sy, zx, zy;
   assign sx = an_ff[WIDTH-1] ^ ad_ff[WIDTH-1];
   assign sy = bn_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
   assign zx = (p1_ff == '0);
   assign zy = (p2_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.comb) begin
         divz_ff <= 1'b0;
         case (op_ff)
            OP_ADD, OP_SUB: begin
               nneg_ff <= sneg_c;
               nmag_ff <= sm_c;
               dneg_ff <= s3_ff;
               dmag_ff <= {1'b0, p3_ff};
            end
            OP_MUL: begin
               nneg_ff <= s4_ff;
               nmag_ff <= {1'b0, p4_ff};
               dneg_ff <= s3_ff;
               dmag_ff <= {1'b0, p3_ff};
            end
            OP_DIV: begin
               if (bn0_ff) begin
                  divz_ff <= 1'b1;
                  nneg_ff <= 1'b0;
                  nmag_ff <= '0;
                  dneg_ff <= ad_ff[WIDTH-1];
                  dmag_ff <= {{(DW-WIDTH){1'b0}}, md};
               end else begin
                  nneg_ff <= s1_ff ^ bn_ff[WIDTH-1];
                  nmag_ff <= ep1;
                  dneg_ff <= ad_ff[WIDTH-1];
                  dmag_ff <= ep2;
               end
            end
            default: begin
               nneg_ff <= 1'b0;
               nmag_ff <= '0;
               dneg_ff <= 1'b0;
               dmag_ff <= '0;
            end
         endcase
         // signed compare of x and y from their magnitudes and signs
         if (zx && zy) begin
            cmp_gt_ff <= 1'b0; cmp_eq_ff <= 1'b1;
         end else if (sx != sy || zx || zy) begin
            cmp_eq_ff <= 1'b0;
            cmp_gt_ff <= zy ? !sx : (zx ? sy : !sx);
         end else begin
            cmp_eq_ff <= (p1_ff == p2_ff);
            cmp_gt_ff <= sx ? (p1_ff < p2_ff) : (p1_ff > p2_ff);
         end
      end
   end

   // shared restoring divider: one quotient bit a cycle while rem_step is set, MSB first
   logic [DW:0]   rsh;
   logic [DW-1:0] dvs;
   logic          fit;
   assign dvs = cmd.qsel_den ? g_ff : (cnt_ff == '0 ? y_ff : y_ff);
   assign rsh = {r_ff, dvd_ff[DW-1]};
   assign fit = (rsh >= {1'b0, dvs});

   assign sts.div_last = (cnt_ff == CW'(DW - 1));
   assign sts.y_zero   = (y_ff == '0);
   assign sts.trivial  = (op_ff > OP_DIV) || (nmag_ff == '0) || (dmag_ff == '0);

   logic [DW-1:0] rnew;
   assign rnew = fit ? DW'(rsh - {1'b0, dvs}) : rsh[DW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.gcd_init) begin
         x_ff   <= nmag_ff;
         y_ff   <= dmag_ff;
         dvd_ff <= nmag_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.qinit) begin
         // on entry from Euclid x holds the divisor g
         if (!cmd.qsel_den) g_ff <= x_ff;
         dvd_ff <= cmd.qsel_den ? dmag_ff : nmag_ff;
         y_ff   <= cmd.qsel_den ? y_ff : x_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.rem_step) begin
         dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         q_ff   <= {q_ff[DW-2:0], fit};
         r_ff   <= rnew;
         cnt_ff <= cnt_ff + 1'b1;
         if (cmd.rem_swap) begin
            x_ff   <= y_ff;
            y_ff   <= rnew;
            dvd_ff <= y_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
      end
      // latch numerator quotient when the numerator pass ends
      if (cmd.qinit && cmd.qsel_den) n_ff <= q_ff;
   end

   // final forms, overflow and status
   logic [DW-1:0] dq;
   logic          neg;
   logic [DW-1:0] lim;
   assign dq  = q_ff;
   assign neg = nneg_ff ^ dneg_ff;
   assign lim = DW'(1) << (WIDTH - 1);

   logic signed [WIDTH-1:0] nres;
   assign nres = neg ? -n_ff[WIDTH-1:0] : n_ff[WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         res_num_ff <= '0;
         res_den_ff <= '0;
         order_ff   <= ORD_LESS;
         status_ff  <= divz_ff ? ST_DIVZ : ST_OK;
         if (op_ff == OP_CMP) begin
            if (ad0_ff || bd0_ff)  order_ff <= ORD_NONE;
            else if (cmp_eq_ff)    order_ff <= ORD_EQUAL;
            else if (cmp_gt_ff)    order_ff <= ORD_GREATER;
            else                   order_ff <= ORD_LESS;
         end else if (op_ff > OP_CMP) begin
            status_ff <= ST_OK;
         end else if (dmag_ff == '0) begin
            if (nmag_ff != '0) res_num_ff <= nneg_ff ? '1 : 32'd1;
         end else if (nmag_ff == '0) begin
            res_den_ff <= 31'd1;
         end else if (dq > lim - 1'b1 || n_ff > (neg ? lim : lim - 1'b1)) begin
            status_ff <= ST_OVFL;
         end else begin
            res_num_ff <= 32'(nres);
            res_den_ff <= 31'(dq);
         end
      end
   end

   assign res_num    = res_num_ff;
   assign res_den    = res_den_ff;
   assign res_order  = order_ff;
   assign res_status = status_ff;

   // the running remainder always stays below the divisor after a step
   a_rem: assert property (@(posedge clock)
      cmd.rem_step && !cmd.rem_swap && dvs != '0 |=> r_ff < $past(dvs))
      else $error("remainder out of range");
   // compare leaves the fraction fields zero
   a_cmp: assert property (@(posedge clock)
      cmd.fin && op_ff == OP_CMP |=> res_num_ff == '0 && res_den_ff == '0)
      else $error("compare fraction not zero");
   // overflow never comes with an order
   a_ovf: assert property (@(posedge clock)
      $past(cmd.fin) && status_ff == ST_OVFL |-> order_ff == ORD_LESS)
      else $error("overflow with order");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for rational_arithmetic_unit: directed table, then random words.
// Depends on rau_pkg and rau_if (src) and the unit's RTL.
module tb_top import rau_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = 32;
   localparam int N_RANDOM = 1100;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } req_word_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0]  order;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type result;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   rsp_word_type fraction_queue[$];

   rau_if #(req_word_type) req_ch (clock);
   rau_if #(rsp_word_type) rsp_ch (clock);

   always #5 clock = ~clock;

   rational_arithmetic_unit #(.WIDTH(WIDTH)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.payload.operation),
      .req_a_num     (req_ch.payload.a_num),
      .req_a_den     (req_ch.payload.a_den),
      .req_b_num     (req_ch.payload.b_num),
      .req_b_den     (req_ch.payload.b_den),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_res_num   (rsp_ch.payload.res_num),
      .rsp_res_den   (rsp_ch.payload.res_den),
      .rsp_order     (rsp_ch.payload.order),
      .rsp_status    (rsp_ch.payload.status)
   );

   function automatic longint unsigned magn(longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // reduce a sign-magnitude fraction into a result word
   function automatic rsp_word_type reduce_fraction(bit nneg, longint unsigned nmag,
                                                    bit dneg, longint unsigned dmag);
      rsp_word_type r;
      longint unsigned lim, g, n, d;
      bit neg;
      lim = 64'd1 << (WIDTH - 1);
      r = '0;
      if (dmag == 0) begin
         r.res_num = (nmag == 0) ? 32'd0 : (nneg ? 32'hFFFF_FFFF : 32'd1);
         return r;
      end
      if (nmag == 0) begin
         r.res_den = 31'd1;
         return r;
      end
      g = gcd64(nmag, dmag);
      n = nmag / g;
      d = dmag / g;
      neg = (nneg != dneg);
      if (d > lim - 1 || n > (neg ? lim : lim - 1)) begin
         r.status = ST_OVFL;
         return r;
      end
      r.res_num = neg ? 32'(-n) : 32'(n);
      r.res_den = 31'(d);
      return r;
   endfunction

   function automatic rsp_word_type predict_fraction(req_word_type w);
      rsp_word_type r;
      longint an, ad, bn, bd, x, y;
      longint unsigned pm, qm, sm;
      bit pneg, qneg, sneg;
      an = longint'(signed'(w.a_num));
      ad = longint'(signed'(w.a_den));
      bn = longint'(signed'(w.b_num));
      bd = longint'(signed'(w.b_den));
      r = '0;
      case (w.operation)
         OP_ADD, OP_SUB: begin
            pneg = (an < 0) != (bd < 0);
            pm = magn(an) * magn(bd);
            qneg = (ad < 0) != (bn < 0);
            qm = magn(ad) * magn(bn);
            if (w.operation == OP_SUB) qneg = !qneg;
            if (pneg == qneg) begin
               sneg = pneg; sm = pm + qm;
            end else if (pm >= qm) begin
               sneg = pneg; sm = pm - qm;
            end else begin
               sneg = qneg; sm = qm - pm;
            end
            r = reduce_fraction(sneg, sm, (ad < 0) != (bd < 0), magn(ad) * magn(bd));
         end
         OP_MUL: begin
            r = reduce_fraction((an < 0) != (bn < 0), magn(an) * magn(bn),
                                (ad < 0) != (bd < 0), magn(ad) * magn(bd));
         end
         OP_DIV: begin
            if (bn == 0) begin
               r = reduce_fraction(1'b0, 0, ad < 0, magn(ad));
               r.status = ST_DIVZ;
            end else begin
               r = reduce_fraction(((an < 0) != (bd < 0)) != (bn < 0), magn(an) * magn(bd),
                                   ad < 0, magn(ad) * magn(bn));
            end
         end
         OP_CMP: begin
            if (ad < 0) begin ad = -ad; an = -an; end
            if (bd < 0) begin bd = -bd; bn = -bn; end
            x = an * bd;
            y = ad * bn;
            if (ad == 0 || bd == 0) r.order = ORD_NONE;
            else if (x > y)         r.order = ORD_GREATER;
            else if (x == y)        r.order = ORD_EQUAL;
            else                    r.order = ORD_LESS;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'(int'($urandom_range(0, 2)) - 1);
         3, 4:    return $urandom;
         5:       return 32'($urandom_range(0, 65535)) - 32'd32768;
         default: return 32'($urandom_range(0, 200)) - 32'd100;
      endcase
   endfunction

   function automatic table_row_type row(logic [2:0] op, int an, int ad, int bn, int bd,
                                         bit typed = 1'b0, logic [31:0] rn = 0,
                                         logic [30:0] rd = 0, logic [1:0] ord = ORD_LESS,
                                         logic [1:0] st = ST_OK);
      table_row_type t;
      t.word = '{op, an, ad, bn, bd};
      t.typed = typed;
      t.result = '{rn, rd, ord, st};
      return t;
   endfunction

   // receiver: stall on its own pattern, with calm stretches
   int stall_left = 0, calm_left = 40;
   always @(negedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
         rsp_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
         case ($urandom_range(0, 7))
            0:       stall_left = $urandom_range(1, 30);
            1:       calm_left = $urandom_range(20, 200);
            2, 3:    stall_left = $urandom_range(1, 3);
            default: ;
         endcase
      end
   end

   // compare each taken result word with the oldest expected one
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (fraction_queue.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, rsp_ch.payload);
            errors++;
         end else begin
            want = fraction_queue.pop_front();
            if (rsp_ch.payload.res_num !== want.res_num) begin
               $display("%0t: res_num expected %h actual %h", $time, want.res_num,
                        rsp_ch.payload.res_num);
               errors++;
            end
            if (rsp_ch.payload.res_den !== want.res_den) begin
               $display("%0t: res_den expected %h actual %h", $time, want.res_den,
                        rsp_ch.payload.res_den);
               errors++;
            end
            if (rsp_ch.payload.order !== want.order) begin
               $display("%0t: order expected %0d actual %0d", $time, want.order,
                        rsp_ch.payload.order);
               errors++;
            end
            if (rsp_ch.payload.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_ch.payload.status);
               errors++;
            end
         end
      end
   end

   // send one word, hold it until taken, then queue its expectation
   task automatic send_word(req_word_type w, bit typed, rsp_word_type typed_result);
      req_ch.payload = w;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      fraction_queue.push_back(typed ? typed_result : predict_fraction(w));
      @(negedge clock);
   endtask

   initial begin
      table_row_type stim[$];
      req_word_type w;
      int burst, gap;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows: extremes, every operation, the special forms
      stim.push_back(row(OP_ADD, 0, 0, 0, 0, 1, 0, 0));
      stim.push_back(row(OP_ADD, 1, 0, 1, 1, 1, 1, 0));
      stim.push_back(row(OP_SUB, -5, 0, 0, 3, 1, 32'hFFFF_FFFF, 0));
      stim.push_back(row(OP_MUL, 0, 7, 3, 4, 1, 0, 1));
      stim.push_back(row(OP_DIV, 3, 4, 0, 5, 1, 0, 1, ORD_LESS, ST_DIVZ));
      stim.push_back(row(OP_DIV, 3, 0, 0, 5, 1, 0, 0, ORD_LESS, ST_DIVZ));
      stim.push_back(row(OP_CMP, 1, 0, 2, 3, 1, 0, 0, ORD_NONE));
      stim.push_back(row(OP_CMP, 1, 2, 2, 4, 1, 0, 0, ORD_EQUAL));
      stim.push_back(row(OP_MUL, 32'h8000_0000, 1, -1, 1, 1, 0, 0, ORD_LESS, ST_OVFL));
      stim.push_back(row(3'd5, 1, 2, 3, 4, 1, 0, 0));
      stim.push_back(row(3'd6, -1, -1, -1, -1, 1, 0, 0));
      stim.push_back(row(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 5, 6, 1, 0, 0));
      stim.push_back(row(OP_ADD, 1, 2, 1, 3));
      stim.push_back(row(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
      stim.push_back(row(OP_SUB, 32'h8000_0000, 32'h8000_0000, 1, -2));
      stim.push_back(row(OP_SUB, 3, -4, -3, 4));
      stim.push_back(row(OP_MUL, 32'h8000_0000, -1, 1, 1));
      stim.push_back(row(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
      stim.push_back(row(OP_DIV, 6, 35, -14, 15));
      stim.push_back(row(OP_DIV, 32'h8000_0000, 1, -1, 1));
      stim.push_back(row(OP_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, -1));
      stim.push_back(row(OP_CMP, -3, -4, 2, 3));
      stim.push_back(row(OP_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      foreach (stim[i]) send_word(stim[i].word, stim[i].typed, stim[i].result);

      // random words in bursts with gaps
      burst = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (burst == 0) begin
            req_ch.valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
            burst = $urandom_range(1, 16);
         end
         burst--;
         w.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
         w.a_num = pick_field();
         w.a_den = pick_field();
         w.b_num = pick_field();
         w.b_den = pick_field();
         send_word(w, 1'b0, '0);
      end
      req_ch.valid = 1'b0;

      // drain, then let the unit settle
      while (fraction_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // hard stop
   initial begin
      #500ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
src/rau_pkg.sv
src/rau_if.sv
src/rau_ctrl.sv
src/rau_dpath.sv
src/rational_arithmetic_unit.sv
verif/tb_top.sv
